>>> rtl/u2a_pkg.sv
package u2a_pkg;

    localparam int KIND_W      = 2;
    localparam int VALUE_W     = 64;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int WORD_W      = 32;
    localparam int NIBBLE_W    = 4;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_W       = BCD_DIGITS * NIBBLE_W;
    localparam int HEX_DIGITS  = VALUE_W / NIBBLE_W;
    localparam int NDIG_W      = $clog2(HEX_DIGITS + 1);
    localparam int ITER_W      = $clog2(WORD_W);

    localparam logic [KIND_W-1:0] KIND_DEC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEX_LO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEX_UP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ADDR   = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_F = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STRIP,
        ST_EMIT
    } u2a_state_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIBBLE_W-1:0] nibble,
                                                   input logic upper);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-NIBBLE_W){1'b0}}, nibble};
        if (nibble < 4'd10) begin
            hex_char = CHAR_ZERO + ext;
        end else if (upper) begin
            hex_char = CHAR_UP_A + ext - 8'd10;
        end else begin
            hex_char = CHAR_LOW_A + ext - 8'd10;
        end
    endfunction

endpackage

>>> rtl/u2a_bcd_step.sv
module u2a_bcd_step
    import u2a_pkg::*;
(
    input  logic [BCD_W-1:0] bcd_in,
    input  logic             bit_in,
    output logic [BCD_W-1:0] bcd_out
);

    logic [BCD_W-1:0] adj;

    // add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_in[i*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
                adj[i*NIBBLE_W +: NIBBLE_W] = bcd_in[i*NIBBLE_W +: NIBBLE_W] + 4'd3;
            end else begin
                adj[i*NIBBLE_W +: NIBBLE_W] = bcd_in[i*NIBBLE_W +: NIBBLE_W];
            end
        end
        bcd_out = {adj[BCD_W-2:0], bit_in};
    end

endmodule

>>> rtl/unsigned_to_ascii_digits.sv
// Prints one unsigned number per input word as ASCII digits, most significant
// first, one output word per character, no leading zeros (zero prints "0").
// s_tuser selects the format: 0 decimal of value[31:0], 1 lowercase hex of
// value[31:0], 2 uppercase hex of value[31:0], 3 lowercase hex of all 64 bits.
// m_tlast marks the final digit; m_tdata[39:8] carries the count of characters
// sent since reset, this one included, wrapping at 2^32. The block takes one
// number at a time and s_tready is low until its last digit is in the output
// register. A hex number first strips its leading zero digits, then sends its
// printed digits; a decimal number is first converted by shift-and-add-3 of all
// 32 bits through one shared BCD step. An output stall holds the digit emission.
module unsigned_to_ascii_digits
    import u2a_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // [63:0] value
    input  logic [KIND_W-1:0]   s_tuser,   // [1:0] kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [7:0] char_code, [39:8] total_count
    output logic                m_tlast    // last_char
);

    u2a_state_t           state_reg, state_next;
    logic [VALUE_W-1:0]   dig_reg, dig_next;
    logic [WORD_W-1:0]    bin_reg, bin_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic [NDIG_W-1:0]    ndig_reg, ndig_next;
    logic                 upper_reg, upper_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic                 mvalid_reg, mvalid_next;
    logic [CHAR_W-1:0]    mchar_reg, mchar_next;
    logic                 mlast_reg, mlast_next;
    logic [BCD_W-1:0]     bcd_shifted;
    logic                 s_accept;
    logic                 out_load;
    logic [NIBBLE_W-1:0]  top_nibble;

    u2a_bcd_step u_bcd_step (
        .bcd_in  (dig_reg[VALUE_W-1 -: BCD_W]),
        .bit_in  (bin_reg[WORD_W-1]),
        .bcd_out (bcd_shifted)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign top_nibble = dig_reg[VALUE_W-1 -: NIBBLE_W];
    assign out_load   = (state_reg == ST_EMIT) && (!mvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            total_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            mvalid_reg <= mvalid_next;
        end
        dig_reg   <= dig_next;
        bin_reg   <= bin_next;
        iter_reg  <= iter_next;
        ndig_reg  <= ndig_next;
        upper_reg <= upper_next;
        mchar_reg <= mchar_next;
        mlast_reg <= mlast_next;
    end

    always_comb begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        bin_next    = bin_reg;
        iter_next   = iter_reg;
        ndig_next   = ndig_reg;
        upper_next  = upper_reg;
        total_next  = total_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mchar_next  = mchar_reg;
        mlast_next  = mlast_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    upper_next = (s_tuser == KIND_HEX_UP);
                    bin_next   = s_tdata[WORD_W-1:0];
                    iter_next  = ITER_W'(WORD_W - 1);
                    case (s_tuser)
                        KIND_DEC: begin
                            dig_next   = '0;
                            ndig_next  = NDIG_W'(BCD_DIGITS);
                            state_next = ST_CONVERT;
                        end
                        KIND_ADDR: begin
                            dig_next   = s_tdata;
                            ndig_next  = NDIG_W'(HEX_DIGITS);
                            state_next = ST_STRIP;
                        end
                        default: begin
                            dig_next   = {s_tdata[WORD_W-1:0], {(VALUE_W-WORD_W){1'b0}}};
                            ndig_next  = NDIG_W'(WORD_W / NIBBLE_W);
                            state_next = ST_STRIP;
                        end
                    endcase
                end
            end
            ST_CONVERT: begin
                dig_next  = {bcd_shifted, {(VALUE_W-BCD_W){1'b0}}};
                bin_next  = {bin_reg[WORD_W-2:0], 1'b0};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == '0) begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                // drop leading zero digits, keep at least one
                if (top_nibble == '0 && ndig_reg != NDIG_W'(1)) begin
                    dig_next  = {dig_reg[VALUE_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    mvalid_next = 1'b1;
                    mchar_next  = hex_char(top_nibble, upper_reg);
                    mlast_next  = (ndig_reg == NDIG_W'(1));
                    total_next  = total_reg + COUNT_W'(1);
                    dig_next    = {dig_reg[VALUE_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                    ndig_next   = ndig_reg - NDIG_W'(1);
                    if (ndig_reg == NDIG_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {total_reg, mchar_reg};

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted while a number is still in progress");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && m_tdata[39:8] == $past(total_reg) + 32'd1)
        else $error("character count did not advance by one");

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STRIP || state_reg == ST_EMIT) |->
            ndig_reg != '0 && ndig_reg <= NDIG_W'(HEX_DIGITS))
        else $error("digit count out of range");

    a_char_is_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] >= CHAR_ZERO && m_tdata[7:0] <= CHAR_NINE) ||
                     (m_tdata[7:0] >= CHAR_LOW_A && m_tdata[7:0] <= CHAR_LOW_F) ||
                     (m_tdata[7:0] >= CHAR_UP_A && m_tdata[7:0] <= CHAR_UP_F))
        else $error("output character is not a digit");

endmodule
